// ===== rtl/linked_queue_with_positional_insert_unit_macros.svh =====
// Assertion macros for the linked queue unit.
`ifndef LINKED_QUEUE_WITH_POSITIONAL_INSERT_UNIT_MACROS_SVH
`define LINKED_QUEUE_WITH_POSITIONAL_INSERT_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LQPI_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LQPI_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define LQPI_CHECK(lbl, cond, msg)
`define LQPI_IMPLY(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/lqpi_pkg.sv =====
// Shared types and constants for the linked queue unit.
`timescale 1ns / 1ps
package lqpi_pkg;
  localparam int POS_BITS = 5;
  localparam int CNT_OUT_BITS = 5;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_INS   = 2'd2,
    OP_PRINT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADIDX = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [POS_BITS-1:0] pos;
  } cmd_t;
endpackage

// ===== rtl/linked_queue_with_positional_insert_unit.sv =====
// Top level of the linked-list queue with positional insert.
//  channel   direction  handshake         payload
//  in_       request    in_push/in_full   command, position, value
//  out_      result     out_empty/out_pop status, item_value, item_count, last
// Enqueue and dequeue each do one link read; insert at position P walks P links
// through the link store with its registered read port, so its time grows with P.
// Print gives one result per element, again one link read each.
// Reset is synchronous; no clearing pass, the free chain comes from per-node valid bits.
// A two-entry request queue lets requests arrive while results stall.
`timescale 1ns / 1ps
module linked_queue_with_positional_insert_unit #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [1:0]                        in_command,
  input  logic [lqpi_pkg::POS_BITS-1:0]     in_position,
  input  logic signed [31:0]                in_value,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [1:0]                        out_status,
  output logic signed [31:0]                out_item_value,
  output logic [lqpi_pkg::CNT_OUT_BITS-1:0] out_item_count,
  output logic                              out_last
);
  import lqpi_pkg::*;

  logic                  cq_valid, cq_pop;
  cmd_t                  cq_cmd;
  logic [VALUE_BITS-1:0] cq_value;

  lqpi_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_command(in_command), .in_position(in_position), .in_value(in_value),
    .cq_valid(cq_valid), .cq_cmd(cq_cmd), .cq_value(cq_value), .cq_pop(cq_pop)
  );

  lqpi_back #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cq_valid(cq_valid), .cq_cmd(cq_cmd), .cq_value(cq_value), .cq_pop(cq_pop),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_status(out_status), .out_item_value(out_item_value),
    .out_item_count(out_item_count), .out_last(out_last)
  );
endmodule

// ===== rtl/lqpi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lqpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/lqpi_front.sv =====
// Front end: accepts requests, decodes the command and queues them for the back end.
`timescale 1ns / 1ps
module lqpi_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [1:0]                     in_command,
  input  logic [lqpi_pkg::POS_BITS-1:0]  in_position,
  input  logic signed [31:0]             in_value,
  output logic                           cq_valid,
  output lqpi_pkg::cmd_t                 cq_cmd,
  output logic [VALUE_BITS-1:0]          cq_value,
  input  logic                           cq_pop
);
  import lqpi_pkg::*;

  cmd_t                  cmd_r [2];
  logic [VALUE_BITS-1:0] val_r [2];
  logic                  wp_r, wp_nxt;
  logic                  rp_r, rp_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  push_ok, pop_ok;
  cmd_t                  dec;

  assign in_full  = (cnt_r == 2'd2);
  assign cq_valid = (cnt_r != 2'd0);
  assign push_ok  = in_push && !in_full;
  assign pop_ok   = cq_pop && cq_valid;
  assign cq_cmd   = cmd_r[rp_r];
  assign cq_value = val_r[rp_r];

  always_comb begin
    dec.op  = op_t'(in_command);
    dec.pos = in_position;
    wp_nxt  = push_ok ? ~wp_r : wp_r;
    rp_nxt  = pop_ok ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push_ok) begin
      cmd_r[wp_r] <= dec;
      val_r[wp_r] <= VALUE_BITS'(in_value);
    end
  end
endmodule

// ===== rtl/lqpi_back.sv =====
// Back end: walks the linked node store and produces results.
`timescale 1ns / 1ps
module lqpi_back #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cq_valid,
  input  lqpi_pkg::cmd_t                    cq_cmd,
  input  logic [VALUE_BITS-1:0]             cq_value,
  output logic                              cq_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [1:0]                        out_status,
  output logic signed [31:0]                out_item_value,
  output logic [lqpi_pkg::CNT_OUT_BITS-1:0] out_item_count,
  output logic                              out_last
);
  import lqpi_pkg::*;
`include "linked_queue_with_positional_insert_unit_macros.svh"

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_BITS) ? CW : POS_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_ENQ, S_DEQ, S_INS_A, S_INS_WALK, S_INS_WAIT, S_INS_DONE, S_PR_RD, S_PR_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PW-1:0]           head_r, head_nxt, tail_r, tail_nxt, free_r, free_nxt;
  logic [PW-1:0]           p_r, p_nxt, n_r, n_nxt, lsave_r, lsave_nxt;
  logic [CW-1:0]           count_r, count_nxt, i_r, i_nxt, k_r, k_nxt;
  logic [POS_BITS-1:0]     pos_r, pos_nxt;
  logic [CAPACITY-1:0]     lv_r, lv_nxt;
  logic [PW-1:0]           la_r, la_nxt;
  logic                    lrv_r, lrv_nxt;
  logic                    out_v_r, out_v_nxt;
  status_t                 st_r, st_nxt;
  logic signed [31:0]      val_r, val_nxt;
  logic [CNT_OUT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    last_r, last_nxt;

  logic                    lre, lwe, vre, vwe;
  logic [PW-1:0]           lra, lwa, lwd, vra, vwa;
  logic [PW-1:0]           lrdata, lnk;
  logic [VALUE_BITS-1:0]   vrdata;
  logic signed [VALUE_BITS-1:0] vsigned;
  logic signed [31:0]      vext;
  logic                    can_emit, full, empty;
  logic [XW-1:0]           pos_x, cnt_x, i_x, cq_pos_x;

  lqpi_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(lwe), .waddr(lwa), .wdata(lwd),
    .re(lre), .raddr(lra), .rdata(lrdata)
  );

  lqpi_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value (
    .clk(clk), .we(vwe), .waddr(vwa), .wdata(cq_value),
    .re(vre), .raddr(vra), .rdata(vrdata)
  );

  // unwritten links read as the reset free chain
  assign lnk = lrv_r ? lrdata :
               ((la_r == PW'(CAPACITY - 1)) ? '0 : la_r + 1'b1);
  assign vsigned  = vrdata;
  assign vext     = 32'(vsigned);
  assign can_emit = !out_v_r || out_pop;
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign pos_x    = XW'(pos_r);
  assign cq_pos_x = XW'(cq_cmd.pos);
  assign cnt_x    = XW'(count_r);
  assign i_x      = XW'(i_r);

  assign out_empty      = !out_v_r;
  assign out_status     = st_r;
  assign out_item_value = val_r;
  assign out_item_count = cnt_r;
  assign out_last       = last_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    free_nxt  = free_r;
    p_nxt     = p_r;
    n_nxt     = n_r;
    lsave_nxt = lsave_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    lv_nxt    = lv_r;
    out_v_nxt = out_pop ? 1'b0 : out_v_r;
    st_nxt    = st_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    cq_pop    = 1'b0;
    lre = 1'b0; lra = '0;
    lwe = 1'b0; lwa = '0; lwd = '0;
    vre = 1'b0; vra = '0;
    vwe = 1'b0; vwa = free_r;

    case (state_r)
      S_IDLE: begin
        if (cq_valid && can_emit) begin
          cq_pop = 1'b1;
          case (cq_cmd.op)
            OP_ENQ: begin
              if (full) begin
                out_v_nxt = 1'b1; st_nxt = ST_FULL; val_nxt = '0;
                cnt_nxt = CNT_OUT_BITS'(cnt_x); last_nxt = 1'b1;
              end else begin
                vwe = 1'b1; lre = 1'b1; lra = free_r; n_nxt = free_r;
                state_nxt = S_ENQ;
              end
            end
            OP_DEQ: begin
              if (empty) begin
                out_v_nxt = 1'b1; st_nxt = ST_EMPTY; val_nxt = '0;
                cnt_nxt = CNT_OUT_BITS'(cnt_x); last_nxt = 1'b1;
              end else begin
                lre = 1'b1; lra = head_r; vre = 1'b1; vra = head_r;
                state_nxt = S_DEQ;
              end
            end
            OP_INS: begin
              out_v_nxt = 1'b1; val_nxt = '0;
              cnt_nxt = CNT_OUT_BITS'(cnt_x); last_nxt = 1'b1;
              if (cq_pos_x > cnt_x) begin
                st_nxt = ST_BADIDX;
              end else if (empty) begin
                st_nxt = ST_EMPTY;
              end else if (full) begin
                st_nxt = ST_FULL;
              end else begin
                out_v_nxt = out_pop ? 1'b0 : out_v_r;
                vwe = 1'b1; lre = 1'b1; lra = free_r; n_nxt = free_r;
                pos_nxt = cq_cmd.pos;
                state_nxt = S_INS_A;
              end
            end
            OP_PRINT: begin
              if (empty) begin
                out_v_nxt = 1'b1; st_nxt = ST_EMPTY; val_nxt = '0;
                cnt_nxt = CNT_OUT_BITS'(cnt_x); last_nxt = 1'b1;
              end else begin
                p_nxt = head_r; k_nxt = '0;
                state_nxt = S_PR_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ENQ: begin
        if (can_emit) begin
          free_nxt = lnk;
          if (empty) begin
            head_nxt = n_r;
          end else begin
            lwe = 1'b1; lwa = tail_r; lwd = n_r;
          end
          tail_nxt  = n_r;
          count_nxt = count_r + 1'b1;
          out_v_nxt = 1'b1; st_nxt = ST_OK; val_nxt = '0;
          cnt_nxt   = CNT_OUT_BITS'(XW'(count_nxt)); last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DEQ: begin
        if (can_emit) begin
          head_nxt  = lnk;
          lwe = 1'b1; lwa = head_r; lwd = free_r;
          free_nxt  = head_r;
          count_nxt = count_r - 1'b1;
          if (count_r == CW'(1)) begin
            tail_nxt = lnk;
          end
          out_v_nxt = 1'b1; st_nxt = ST_OK; val_nxt = vext;
          cnt_nxt   = CNT_OUT_BITS'(XW'(count_nxt)); last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INS_A: begin
        free_nxt = lnk;
        if (pos_r == '0) begin
          lwe = 1'b1; lwa = n_r; lwd = head_r;
          head_nxt  = n_r;
          state_nxt = S_INS_DONE;
        end else begin
          p_nxt = head_r; i_nxt = CW'(1);
          state_nxt = S_INS_WALK;
        end
      end
      S_INS_WALK: begin
        lre = 1'b1; lra = p_r;
        state_nxt = S_INS_WAIT;
      end
      S_INS_WAIT: begin
        if (i_x < pos_x) begin
          p_nxt = lnk; i_nxt = i_r + 1'b1;
          state_nxt = S_INS_WALK;
        end else begin
          lsave_nxt = lnk;
          lwe = 1'b1; lwa = p_r; lwd = n_r;
          state_nxt = S_INS_DONE;
        end
      end
      S_INS_DONE: begin
        if (can_emit) begin
          if (pos_r != '0) begin
            lwe = 1'b1; lwa = n_r; lwd = lsave_r;
          end
          if (pos_x == cnt_x) begin
            tail_nxt = n_r;
          end
          count_nxt = count_r + 1'b1;
          out_v_nxt = 1'b1; st_nxt = ST_OK; val_nxt = '0;
          cnt_nxt   = CNT_OUT_BITS'(XW'(count_nxt)); last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PR_RD: begin
        lre = 1'b1; lra = p_r; vre = 1'b1; vra = p_r;
        state_nxt = S_PR_EMIT;
      end
      S_PR_EMIT: begin
        if (can_emit) begin
          out_v_nxt = 1'b1; st_nxt = ST_OK; val_nxt = vext;
          cnt_nxt   = CNT_OUT_BITS'(cnt_x);
          last_nxt  = (k_r + 1'b1 == count_r);
          p_nxt     = lnk;
          k_nxt     = k_r + 1'b1;
          state_nxt = last_nxt ? S_IDLE : S_PR_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (lwe) begin
      lv_nxt[lwa] = 1'b1;
    end
  end

  always_comb begin
    la_nxt  = lre ? lra : la_r;
    lrv_nxt = lre ? lv_r[lra] : lrv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      free_r  <= '0;
      count_r <= '0;
      lv_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      free_r  <= free_nxt;
      count_r <= count_nxt;
      lv_r    <= lv_nxt;
      out_v_r <= out_v_nxt;
    end
    p_r     <= p_nxt;
    n_r     <= n_nxt;
    lsave_r <= lsave_nxt;
    i_r     <= i_nxt;
    k_r     <= k_nxt;
    pos_r   <= pos_nxt;
    la_r    <= la_nxt;
    lrv_r   <= lrv_nxt;
    st_r    <= st_nxt;
    val_r   <= val_nxt;
    cnt_r   <= cnt_nxt;
    last_r  <= last_nxt;
  end

  `LQPI_CHECK(a_count_bound, count_r <= CW'(CAPACITY), "element count above capacity")
  `LQPI_IMPLY(a_single_node, count_r == CW'(1), head_r == tail_r, "head and tail differ")
  `LQPI_IMPLY(a_no_take_blocked, state_r == S_IDLE && !can_emit, !cq_pop, "request taken while result slot busy")
  `LQPI_IMPLY(a_walk_in_list, state_r == S_INS_WAIT, i_x <= pos_x && pos_x < cnt_x + XW'(1), "insert walk out of range")
endmodule

// ===== tb/sv/linked_queue_with_positional_insert_unit_tb.sv =====
// Self-checking testbench for the linked-list queue with positional insert.
`timescale 1ns / 1ps
module linked_queue_with_positional_insert_unit_tb;
  import lqpi_pkg::*;

  localparam int CAP = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    status_t     st;
    logic [31:0] val;
    logic [4:0]  cnt;
    logic        lst;
  } outcome_t;

  typedef struct {
    op_t         op;
    logic [4:0]  pos;
    logic [31:0] val;
    logic        has_exp;
    status_t     exp_st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_command = '0;
  logic [4:0] in_position = '0;
  logic signed [31:0] in_value = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [1:0] out_status;
  logic signed [31:0] out_item_value;
  logic [4:0] out_item_count;
  logic out_last;

  logic [31:0] node_val [CAP];
  logic [3:0]  node_link [CAP];
  logic [3:0]  head, tail, free_head;
  int          held;
  outcome_t    pending [$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          stim_done = 1'b0;

  linked_queue_with_positional_insert_unit DUT (.*);

  always #6 clk = ~clk;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void list_reset();
    for (int i = 0; i < CAP; i++) begin
      node_val[i] = '0;
      node_link[i] = 4'((i + 1) % CAP);
    end
    head = 0; tail = 0; free_head = 0; held = 0;
  endfunction

  function automatic void push_outcome(status_t s, logic [31:0] v, logic l);
    outcome_t o;
    o.st = s; o.val = v; o.cnt = 5'(held); o.lst = l;
    pending.push_back(o);
  endfunction

  function automatic logic [3:0] grab_node(logic [31:0] v);
    logic [3:0] n;
    n = free_head;
    free_head = node_link[n];
    node_val[n] = v;
    return n;
  endfunction

  function automatic void predict_queue(op_t op, logic [4:0] pos, logic [31:0] v);
    logic [3:0] n, p;
    case (op)
      OP_ENQ: begin
        if (held >= CAP) push_outcome(ST_FULL, 0, 1);
        else begin
          n = grab_node(v);
          if (held == 0) head = n;
          else node_link[tail] = n;
          tail = n; held++;
          push_outcome(ST_OK, 0, 1);
        end
      end
      OP_DEQ: begin
        if (held == 0) push_outcome(ST_EMPTY, 0, 1);
        else begin
          n = head;
          head = node_link[n];
          node_link[n] = free_head;
          free_head = n;
          held--;
          if (held == 0) tail = head;
          push_outcome(ST_OK, node_val[n], 1);
        end
      end
      OP_INS: begin
        if (pos > held) push_outcome(ST_BADIDX, 0, 1);
        else if (held == 0) push_outcome(ST_EMPTY, 0, 1);
        else if (held >= CAP) push_outcome(ST_FULL, 0, 1);
        else begin
          n = grab_node(v);
          if (pos == 0) begin
            node_link[n] = head; head = n;
          end else begin
            p = head;
            for (int i = 1; i < pos; i++) p = node_link[p];
            node_link[n] = node_link[p];
            node_link[p] = n;
            if (pos == held) tail = n;
          end
          held++;
          push_outcome(ST_OK, 0, 1);
        end
      end
      default: begin
        if (held == 0) push_outcome(ST_EMPTY, 0, 1);
        else begin
          p = head;
          for (int k = 0; k < held; k++) begin
            push_outcome(ST_OK, node_val[p], k + 1 == held);
            p = node_link[p];
          end
        end
      end
    endcase
  endfunction

  task automatic send(input op_t op, input logic [4:0] pos, input logic [31:0] v);
    if (!calm) begin
      while ($urandom_range(99) < 15) begin
        in_push <= 1'b0;
        @(negedge clk);
      end
    end
    in_push <= 1'b1;
    in_command <= op;
    in_position <= pos;
    in_value <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_queue(op, pos, v);
    @(negedge clk);
  endtask

  // directed table: expected status typed only where obvious
  row_t rows [$];
  function automatic void add_row(op_t op, logic [4:0] pos, logic [31:0] v,
                                  logic he, status_t es);
    row_t r;
    r.op = op; r.pos = pos; r.val = v; r.has_exp = he; r.exp_st = es;
    rows.push_back(r);
  endfunction

  always @(posedge clk) begin
    outcome_t w;
    if (rst_n && !out_empty && out_pop) begin
      if (pending.size() == 0) report("unexpected result", out_status, 0);
      else begin
        w = pending.pop_front();
        if (out_status != w.st) report("status", out_status, w.st);
        if (out_item_value != w.val) report("item_value", out_item_value, w.val);
        if (out_item_count != w.cnt) report("item_count", out_item_count, w.cnt);
        if (out_last != w.lst) report("last", out_last, w.lst);
      end
    end
  end

  always @(negedge clk) begin
    out_pop <= calm ? 1'b1 : ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int wr, op_pick, cnt_snap;
    list_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(OP_DEQ, 0, 0, 1, ST_EMPTY);
    add_row(OP_PRINT, 0, 0, 1, ST_EMPTY);
    add_row(OP_INS, 0, 32'h5, 1, ST_EMPTY);
    add_row(OP_INS, 5'd31, 32'h5, 1, ST_BADIDX);
    add_row(OP_ENQ, 0, 32'h7FFF_FFFF, 1, ST_OK);
    add_row(OP_ENQ, 0, 32'h8000_0000, 1, ST_OK);
    add_row(OP_INS, 0, 32'hFFFF_FFFF, 0, ST_OK);
    add_row(OP_INS, 3, 32'h0, 0, ST_OK);
    add_row(OP_INS, 2, 32'h1234_5678, 0, ST_OK);
    add_row(OP_INS, 9, 32'h1, 1, ST_BADIDX);
    add_row(OP_PRINT, 0, 0, 0, ST_OK);
    for (int i = 0; i < 11; i++) add_row(OP_ENQ, 0, 32'(i * 32'h1111_1111), 0, ST_OK);
    add_row(OP_ENQ, 0, 32'h1, 1, ST_FULL);
    add_row(OP_INS, 16, 32'h1, 1, ST_FULL);
    add_row(OP_PRINT, 0, 0, 0, ST_OK);
    add_row(OP_DEQ, 0, 0, 0, ST_OK);

    foreach (rows[i]) begin
      cnt_snap = pending.size();
      send(rows[i].op, rows[i].pos, rows[i].val);
      if (rows[i].has_exp && pending.size() > cnt_snap &&
          pending[cnt_snap].st != rows[i].exp_st)
        report("table status", pending[cnt_snap].st, rows[i].exp_st);
    end

    for (int i = 0; i < 360; i++) begin
      if (i == 120) begin
        in_push <= 1'b0;
        while (pending.size() != 0) @(negedge clk);
      end
      calm = (i >= 200 && i < 260);
      op_pick = $urandom_range(99);
      if (held < 3 && op_pick < 60) op_pick = 0;
      if (held > 13 && op_pick < 40) op_pick = 35;
      wr = $urandom_range(held);
      if ($urandom_range(9) == 0) wr = $urandom_range(31);
      if (op_pick < 35) send(OP_ENQ, 5'($urandom), $urandom);
      else if (op_pick < 60) send(OP_DEQ, 5'($urandom), $urandom);
      else if (op_pick < 92) send(OP_INS, 5'(wr), $urandom);
      else send(OP_PRINT, 5'($urandom), $urandom);
    end
    calm = 1'b0;
    in_push <= 1'b0;

    while (pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lqpi_pkg.sv
rtl/lqpi_ram.sv
rtl/lqpi_front.sv
rtl/lqpi_back.sv
rtl/linked_queue_with_positional_insert_unit.sv
tb/sv/linked_queue_with_positional_insert_unit_tb.sv
